// ===== hdl/sasl_pkg.sv =====
// sasl_pkg: shared types and constants for the stab address lookup block
// no dependencies

package sasl_pkg;

   localparam logic [7:0] TYPE_FUN   = 8'h24;
   localparam logic [7:0] TYPE_SLINE = 8'h44;
   localparam logic [7:0] TYPE_SO    = 8'h64;
   localparam logic [7:0] TYPE_SOL   = 8'h84;
   localparam logic [7:0] TYPE_PSYM  = 8'hA0;

   localparam logic [1:0] STATUS_FOUND   = 2'd0;
   localparam logic [1:0] STATUS_BAD     = 2'd1;
   localparam logic [1:0] STATUS_NO_FILE = 2'd2;
   localparam logic [1:0] STATUS_NO_LINE = 2'd3;

   localparam logic [1:0] REG_ENTRY_COUNT = 2'd0;
   localparam logic [1:0] REG_STR_SIZE    = 2'd1;
   localparam logic [1:0] REG_STR_VALID   = 2'd2;
   localparam logic [1:0] REG_KERNEL_BASE = 2'd3;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // search phase of a query; file also marks the backward file scan
   localparam logic [1:0] PHASE_FILE      = 2'd0;
   localparam logic [1:0] PHASE_FUN       = 2'd1;
   localparam logic [1:0] PHASE_LINE      = 2'd2;
   localparam logic [1:0] PHASE_FILE_NAME = 2'd3;

   localparam int ENTRY_WIDTH = 88;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH_TOP,
      ST_SCAN_ISSUE,
      ST_SCAN_WAIT,
      ST_SEARCH_END,
      ST_TAIL_ISSUE,
      ST_TAIL_WAIT,
      ST_FILE_ISSUE,
      ST_FILE_WAIT,
      ST_ARGS_ISSUE,
      ST_ARGS_WAIT,
      ST_DONE
   } state_type;

endpackage

// ===== hdl/sasl_ram.sv =====
// sasl_ram: generic single-port RAM with registered read
// no dependencies

module sasl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] address,
   input  logic [WIDTH-1:0]         write_data,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[address] <= write_data;
      end
      read_data <= mem_ff[address];
   end

endmodule

// ===== hdl/stab_address_symbol_lookup.sv =====
// stab_address_symbol_lookup: top level, registers, sequencer and entry table
// depends on sasl_pkg and sasl_ram
//
// channel   direction  handshake            payload
// req_      in         start && !busy       opcode, entry fields, query address
// rsp_      out        rsp_valid one cycle  status, line, function, file, args
// csr_      in/out     apb, pready high     four registers at 4*i
//
// a write transaction writes the table when accepted; the wr_gap register then holds busy high
// a query below kernel_base or with an invalid string table goes from idle straight to done
// other queries run up to three binary searches with backward type scans, a file
// scan and an argument scan, all through the single table read port
// reset is synchronous and clears control state; the table is not cleared
// the result strobe cannot be stalled

module stab_address_symbol_lookup #(
   parameter int TABLE_DEPTH = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_opcode,
   input  logic [11:0] req_entry_index,
   input  logic [7:0]  req_entry_type,
   input  logic [31:0] req_entry_value,
   input  logic [31:0] req_entry_string_offset,
   input  logic [15:0] req_entry_desc,
   input  logic [31:0] req_query_address,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_line_number,
   output logic [31:0] rsp_function_address,
   output logic [31:0] rsp_function_name_offset,
   output logic        rsp_function_name_known,
   output logic [31:0] rsp_file_name_offset,
   output logic        rsp_file_name_known,
   output logic [11:0] rsp_argument_count,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int AW = $clog2(TABLE_DEPTH);
   // signed index range -1 .. TABLE_DEPTH
   localparam int IW = AW + 2;
   localparam logic signed [IW-1:0] ONE = IW'(1);

   logic [12:0] entry_count_ff;
   logic [31:0] str_size_ff;
   logic        str_valid_ff;
   logic [31:0] kernel_base_ff;

   assign pready = 1'b1;
   wire csr_write = psel && penable && pwrite;
   wire [1:0] csr_reg = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
         str_size_ff    <= '0;
         str_valid_ff   <= 1'b0;
         kernel_base_ff <= 32'hC000_0000;
      end else if (csr_write) begin
         unique case (csr_reg)
            sasl_pkg::REG_ENTRY_COUNT: entry_count_ff <= pwdata[12:0];
            sasl_pkg::REG_STR_SIZE:    str_size_ff    <= pwdata;
            sasl_pkg::REG_STR_VALID:   str_valid_ff   <= pwdata[0];
            sasl_pkg::REG_KERNEL_BASE: kernel_base_ff <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_reg)
         sasl_pkg::REG_ENTRY_COUNT: prdata = {19'd0, entry_count_ff};
         sasl_pkg::REG_STR_SIZE:    prdata = str_size_ff;
         sasl_pkg::REG_STR_VALID:   prdata = {31'd0, str_valid_ff};
         sasl_pkg::REG_KERNEL_BASE: prdata = kernel_base_ff;
         default:                   prdata = '0;
      endcase
   end

   // table ram
   logic                ram_we;
   logic [AW-1:0]       ram_addr;
   logic [sasl_pkg::ENTRY_WIDTH-1:0] ram_wdata, ram_rdata;

   sasl_ram #(.WIDTH(sasl_pkg::ENTRY_WIDTH), .DEPTH(TABLE_DEPTH)) u_table (
      .clock(clock), .write_enable(ram_we), .address(ram_addr),
      .write_data(ram_wdata), .read_data(ram_rdata)
   );

   wire [7:0]  rd_type  = ram_rdata[87:80];
   wire [31:0] rd_value = ram_rdata[79:48];
   wire [31:0] rd_strx  = ram_rdata[47:16];
   wire [15:0] rd_desc  = ram_rdata[15:0];

   // sequencer registers
   sasl_pkg::state_type state_ff, state_in;
   logic signed [IW-1:0] lo_ff, lo_in, hi_ff, hi_in;     // *lo, *hi
   logic signed [IW-1:0] l_ff, l_in, r_ff, r_in;         // search window
   logic signed [IW-1:0] mid_ff, mid_in, m_ff, m_in;     // probe and scan
   logic        matched_ff, matched_in;
   logic [1:0]  phase_ff, phase_in;
   logic [31:0] key_ff, key_in, addr_ff, addr_in;
   logic signed [IW-1:0] lfile_ff, lfile_in, rfile_ff, rfile_in;
   logic signed [IW-1:0] lfun_ff, lfun_in, rfun_ff, rfun_in;
   logic        fun_found_ff, fun_found_in;
   logic [1:0]  status_ff, status_in;
   logic [15:0] line_ff, line_in;
   logic [31:0] fn_addr_ff, fn_addr_in, fn_off_ff, fn_off_in;
   logic        fn_known_ff, fn_known_in;
   logic [31:0] file_off_ff, file_off_in;
   logic        file_known_ff, file_known_in;
   logic [11:0] nargs_ff, nargs_in;
   logic        wr_gap_ff;

   wire accept = start && !busy;
   assign busy = (state_ff != sasl_pkg::ST_IDLE) || wr_gap_ff;

   logic [7:0] search_type;
   always_comb begin
      unique case (phase_ff)
         sasl_pkg::PHASE_FILE: search_type = sasl_pkg::TYPE_SO;
         sasl_pkg::PHASE_FUN:  search_type = sasl_pkg::TYPE_FUN;
         default:              search_type = sasl_pkg::TYPE_SLINE;
      endcase
   end

   // indices outside the table read as zero
   logic signed [IW-1:0] rd_idx_ff;
   wire rd_in_table = (rd_idx_ff >= 0) && (rd_idx_ff < IW'(TABLE_DEPTH));
   wire [7:0]  e_type  = rd_in_table ? rd_type  : 8'd0;
   wire [31:0] e_value = rd_in_table ? rd_value : 32'd0;
   wire [31:0] e_strx  = rd_in_table ? rd_strx  : 32'd0;
   wire [15:0] e_desc  = rd_in_table ? rd_desc  : 16'd0;

   logic signed [IW-1:0] rd_idx;
   always_ff @(posedge clock) rd_idx_ff <= rd_idx;

   wire signed [IW:0] lr_sum = {l_ff[IW-1], l_ff} + {r_ff[IW-1], r_ff};
   // c division truncates toward zero
   wire signed [IW-1:0] mid_calc = (lr_sum < 0) ? IW'((lr_sum + 1) >>> 1)
                                                : IW'(lr_sum >>> 1);
   wire [12:0] count_sat = (32'(entry_count_ff) > 32'(TABLE_DEPTH))
                           ? 13'(TABLE_DEPTH) : entry_count_ff;

   always_comb begin
      state_in = state_ff;
      lo_in = lo_ff; hi_in = hi_ff; l_in = l_ff; r_in = r_ff;
      mid_in = mid_ff; m_in = m_ff; matched_in = matched_ff;
      phase_in = phase_ff; key_in = key_ff; addr_in = addr_ff;
      lfile_in = lfile_ff; rfile_in = rfile_ff;
      lfun_in = lfun_ff; rfun_in = rfun_ff; fun_found_in = fun_found_ff;
      status_in = status_ff; line_in = line_ff;
      fn_addr_in = fn_addr_ff; fn_off_in = fn_off_ff; fn_known_in = fn_known_ff;
      file_off_in = file_off_ff; file_known_in = file_known_ff;
      nargs_in = nargs_ff;
      rd_idx = m_ff;
      unique case (state_ff)
         sasl_pkg::ST_IDLE: begin
            if (accept && req_opcode == sasl_pkg::OP_QUERY) begin
               addr_in = req_query_address;
               key_in = req_query_address;
               fn_addr_in = req_query_address;
               fn_off_in = '0; fn_known_in = 1'b0;
               file_off_in = '0; file_known_in = 1'b0;
               nargs_in = '0; line_in = '0;
               if (req_query_address < kernel_base_ff || !str_valid_ff) begin
                  status_in = sasl_pkg::STATUS_BAD;
                  state_in = sasl_pkg::ST_DONE;
               end else begin
                  phase_in = sasl_pkg::PHASE_FILE;
                  lo_in = '0; l_in = '0;
                  hi_in = IW'(count_sat) - ONE; r_in = IW'(count_sat) - ONE;
                  matched_in = 1'b0;
                  state_in = sasl_pkg::ST_SEARCH_TOP;
               end
            end
         end
         sasl_pkg::ST_SEARCH_TOP: begin
            if (l_ff <= r_ff) begin
               mid_in = mid_calc;
               m_in = mid_calc;
               state_in = sasl_pkg::ST_SCAN_ISSUE;
            end else begin
               state_in = sasl_pkg::ST_SEARCH_END;
            end
         end
         sasl_pkg::ST_SCAN_ISSUE: begin
            if (m_ff < l_ff) begin
               l_in = mid_ff + ONE;
               state_in = sasl_pkg::ST_SEARCH_TOP;
            end else begin
               rd_idx = m_ff;
               state_in = sasl_pkg::ST_SCAN_WAIT;
            end
         end
         sasl_pkg::ST_SCAN_WAIT: begin
            if (e_type != search_type) begin
               m_in = m_ff - ONE;
               state_in = sasl_pkg::ST_SCAN_ISSUE;
            end else begin
               matched_in = 1'b1;
               state_in = sasl_pkg::ST_SEARCH_TOP;
               if (e_value < key_ff) begin
                  lo_in = m_ff; l_in = mid_ff + ONE;
               end else if (e_value > key_ff) begin
                  hi_in = m_ff - ONE; r_in = m_ff - ONE;
               end else begin
                  lo_in = m_ff; l_in = m_ff; key_in = key_ff + 32'd1;
               end
            end
         end
         sasl_pkg::ST_SEARCH_END: begin
            if (!matched_ff) begin
               // finish phase with lo unchanged
               hi_in = lo_ff - ONE;
               m_in = lo_ff;
               state_in = sasl_pkg::ST_TAIL_WAIT;
            end else begin
               m_in = hi_ff;
               state_in = sasl_pkg::ST_TAIL_ISSUE;
            end
         end
         sasl_pkg::ST_TAIL_ISSUE: begin
            if (m_ff > lo_ff) begin
               rd_idx = m_ff;
               state_in = sasl_pkg::ST_TAIL_WAIT;
               matched_in = 1'b1;
            end else begin
               lo_in = m_ff;
               matched_in = 1'b0; // marks phase completion in TAIL_WAIT
               state_in = sasl_pkg::ST_TAIL_WAIT;
            end
         end
         sasl_pkg::ST_TAIL_WAIT: begin
            if (matched_ff && e_type != search_type) begin
               m_in = m_ff - ONE;
               state_in = sasl_pkg::ST_TAIL_ISSUE;
            end else begin
               // phase result: lo = m, hi = hi_ff
               logic signed [IW-1:0] plo;
               plo = m_ff;
               matched_in = 1'b0;
               unique case (phase_ff)
                  sasl_pkg::PHASE_FILE: begin
                     lfile_in = plo; rfile_in = hi_ff;
                     if (plo == 0) begin
                        status_in = sasl_pkg::STATUS_NO_FILE;
                        state_in = sasl_pkg::ST_DONE;
                     end else begin
                        phase_in = sasl_pkg::PHASE_FUN;
                        lo_in = plo; l_in = plo; hi_in = hi_ff; r_in = hi_ff;
                        key_in = addr_ff;
                        state_in = sasl_pkg::ST_SEARCH_TOP;
                     end
                  end
                  sasl_pkg::PHASE_FUN: begin
                     lfun_in = plo; rfun_in = hi_ff;
                     phase_in = sasl_pkg::PHASE_LINE;
                     if (plo <= hi_ff) begin
                        fun_found_in = 1'b1;
                        rd_idx = plo;
                        m_in = plo;
                        state_in = sasl_pkg::ST_FILE_ISSUE; // fetch fun entry
                     end else begin
                        fun_found_in = 1'b0;
                        lo_in = lfile_ff; l_in = lfile_ff;
                        hi_in = rfile_ff; r_in = rfile_ff;
                        key_in = addr_ff;
                        state_in = sasl_pkg::ST_SEARCH_TOP;
                     end
                  end
                  default: begin
                     if (plo > hi_ff) begin
                        status_in = sasl_pkg::STATUS_NO_LINE;
                        state_in = sasl_pkg::ST_DONE;
                     end else begin
                        phase_in = sasl_pkg::PHASE_FILE_NAME;
                        rd_idx = hi_ff;
                        m_in = plo;
                        state_in = sasl_pkg::ST_FILE_ISSUE;
                     end
                  end
               endcase
            end
         end
         sasl_pkg::ST_FILE_ISSUE: begin
            // from TAIL_WAIT, entered in the cycle after it issued a read; from FILE_WAIT, to step back
            state_in = sasl_pkg::ST_FILE_WAIT;
            if (phase_ff == sasl_pkg::PHASE_LINE) begin
               // function entry data
               if (e_strx < str_size_ff) begin
                  fn_off_in = e_strx; fn_known_in = 1'b1;
               end
               fn_addr_in = e_value;
               key_in = addr_ff - e_value;
               lo_in = lfun_ff; l_in = lfun_ff; hi_in = rfun_ff; r_in = rfun_ff;
               state_in = sasl_pkg::ST_SEARCH_TOP;
            end else if (phase_ff == sasl_pkg::PHASE_FILE_NAME) begin
               line_in = e_desc;
               phase_in = sasl_pkg::PHASE_FILE; // reuse as file scan marker
               if (m_ff >= lfile_ff) begin
                  rd_idx = m_ff;
               end else begin
                  state_in = sasl_pkg::ST_ARGS_ISSUE;
               end
            end else if (m_ff >= lfile_ff) begin
               rd_idx = m_ff;
            end else begin
               state_in = sasl_pkg::ST_ARGS_ISSUE;
            end
         end
         sasl_pkg::ST_FILE_WAIT: begin
            if (e_type == sasl_pkg::TYPE_SOL
                || (e_type == sasl_pkg::TYPE_SO && e_value != 32'd0)) begin
               if (e_strx < str_size_ff) begin
                  file_off_in = e_strx; file_known_in = 1'b1;
               end
               state_in = sasl_pkg::ST_ARGS_ISSUE;
            end else begin
               m_in = m_ff - ONE;
               state_in = sasl_pkg::ST_FILE_ISSUE;
            end
         end
         sasl_pkg::ST_ARGS_ISSUE: begin
            if (!fun_found_ff || !(lfun_ff < rfun_ff)) begin
               status_in = sasl_pkg::STATUS_FOUND;
               state_in = sasl_pkg::ST_DONE;
            end else begin
               m_in = lfun_ff + ONE;
               state_in = sasl_pkg::ST_ARGS_WAIT;
               fun_found_in = 1'b0;
               matched_in = 1'b0;
            end
         end
         sasl_pkg::ST_ARGS_WAIT: begin
            // matched flags a read in flight
            if (!matched_ff) begin
               if (m_ff < rfun_ff) begin
                  rd_idx = m_ff;
                  matched_in = 1'b1;
               end else begin
                  status_in = sasl_pkg::STATUS_FOUND;
                  state_in = sasl_pkg::ST_DONE;
               end
            end else begin
               matched_in = 1'b0;
               if (e_type == sasl_pkg::TYPE_PSYM) begin
                  if (nargs_ff != 12'hFFF) nargs_in = nargs_ff + 12'd1;
                  m_in = m_ff + ONE;
               end else begin
                  status_in = sasl_pkg::STATUS_FOUND;
                  state_in = sasl_pkg::ST_DONE;
               end
            end
         end
         sasl_pkg::ST_DONE: begin
            state_in = sasl_pkg::ST_IDLE;
            matched_in = 1'b0;
            fun_found_in = 1'b0;
         end
         default: state_in = sasl_pkg::ST_IDLE;
      endcase
   end

   // a write transaction takes the table port, otherwise the sequencer reads
   always_comb begin
      ram_we = 1'b0;
      ram_wdata = {req_entry_type, req_entry_value, req_entry_string_offset,
                   req_entry_desc};
      ram_addr = rd_idx[AW-1:0];
      if (accept && req_opcode == sasl_pkg::OP_WRITE) begin
         ram_we = (32'(req_entry_index) < 32'(TABLE_DEPTH));
         ram_addr = AW'(req_entry_index);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sasl_pkg::ST_IDLE;
         wr_gap_ff <= 1'b0;
         matched_ff <= 1'b0;
         fun_found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         wr_gap_ff <= accept && req_opcode == sasl_pkg::OP_WRITE;
         matched_ff <= matched_in;
         fun_found_ff <= fun_found_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in; hi_ff <= hi_in; l_ff <= l_in; r_ff <= r_in;
      mid_ff <= mid_in; m_ff <= m_in;
      phase_ff <= phase_in; key_ff <= key_in; addr_ff <= addr_in;
      lfile_ff <= lfile_in; rfile_ff <= rfile_in;
      lfun_ff <= lfun_in; rfun_ff <= rfun_in;
      status_ff <= status_in; line_ff <= line_in;
      fn_addr_ff <= fn_addr_in; fn_off_ff <= fn_off_in; fn_known_ff <= fn_known_in;
      file_off_ff <= file_off_in; file_known_ff <= file_known_in;
      nargs_ff <= nargs_in;
   end

   wire fields_kept = (status_ff == sasl_pkg::STATUS_FOUND)
                      || (status_ff == sasl_pkg::STATUS_NO_LINE);
   wire all_kept = (status_ff == sasl_pkg::STATUS_FOUND);

   assign rsp_valid = (state_ff == sasl_pkg::ST_DONE);
   assign rsp_status = status_ff;
   assign rsp_line_number = all_kept ? line_ff : 16'd0;
   assign rsp_function_address = fields_kept ? fn_addr_ff : addr_ff;
   assign rsp_function_name_offset = fields_kept ? fn_off_ff : 32'd0;
   assign rsp_function_name_known = fields_kept ? fn_known_ff : 1'b0;
   assign rsp_file_name_offset = all_kept ? file_off_ff : 32'd0;
   assign rsp_file_name_known = all_kept ? file_known_ff : 1'b0;
   assign rsp_argument_count = all_kept ? nargs_ff : 12'd0;

endmodule

// ===== hdl/sasl_checker.sv =====
// sasl_checker: port-level assertions for stab_address_symbol_lookup
// depends on sasl_pkg; bound to the top level below

module sasl_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        req_opcode,
   input logic        rsp_valid,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_line_number,
   input logic        rsp_file_name_known
);

   // a write transaction never produces a result
   a_write_silent: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_opcode == sasl_pkg::OP_WRITE |=> !rsp_valid)
      else $error("result after write");

   // results come only while busy
   a_result_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result while idle");

   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != sasl_pkg::STATUS_FOUND
      |-> rsp_line_number == 16'd0 && !rsp_file_name_known)
      else $error("failed lookup carries line data");

endmodule

bind stab_address_symbol_lookup sasl_checker u_sasl_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .req_opcode(req_opcode), .rsp_valid(rsp_valid), .rsp_status(rsp_status),
   .rsp_line_number(rsp_line_number), .rsp_file_name_known(rsp_file_name_known)
);

// ===== dv/stab_address_symbol_lookup_tb.sv =====
// stab_address_symbol_lookup_tb: self-checking testbench for the stab address lookup block
// depends on sasl_pkg and stab_address_symbol_lookup; a built-in predictor checks every result
`timescale 1ns / 100ps

module stab_address_symbol_lookup_tb;

   localparam int DEPTH = 4096;
   // slots written before any query; every search stays below this
   localparam int FILL = 640;
   localparam int STALL_LIMIT = 500000;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] line;
      logic [31:0] fn_addr;
      logic [31:0] fn_off;
      logic        fn_known;
      logic [31:0] file_off;
      logic        file_known;
      logic [11:0] nargs;
   } lookup_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic        req_opcode = sasl_pkg::OP_WRITE;
   logic [11:0] req_entry_index = '0;
   logic [7:0]  req_entry_type = '0;
   logic [31:0] req_entry_value = '0;
   logic [31:0] req_entry_string_offset = '0;
   logic [15:0] req_entry_desc = '0;
   logic [31:0] req_query_address = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_line_number;
   logic [31:0] rsp_function_address;
   logic [31:0] rsp_function_name_offset;
   logic        rsp_function_name_known;
   logic [31:0] rsp_file_name_offset;
   logic        rsp_file_name_known;
   logic [11:0] rsp_argument_count;
   logic        psel = 0;
   logic        penable = 0;
   logic        pwrite = 0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // mirror of the symbol table and registers
   logic [7:0]  sym_type [DEPTH];
   logic [31:0] sym_value [DEPTH];
   logic [31:0] sym_strx [DEPTH];
   logic [15:0] sym_desc [DEPTH];
   logic [12:0] cfg_count = '0;
   logic [31:0] cfg_str_size = '0;
   logic        cfg_str_valid = 0;
   logic [31:0] cfg_base = 32'hC000_0000;

   lookup_type pending_lookups[$];
   int      errors = 0;
   int      gap_pct = 0;
   int      stall_cycles = 0;
   logic [31:0] sess_lo, sess_hi;

   stab_address_symbol_lookup DUT (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   function automatic logic [7:0] type_at(int i);
      return (i >= 0 && i < DEPTH) ? sym_type[i] : 8'h00;
   endfunction

   function automatic logic [31:0] value_at(int i);
      return (i >= 0 && i < DEPTH) ? sym_value[i] : 32'h0;
   endfunction

   function automatic logic [31:0] strx_at(int i);
      return (i >= 0 && i < DEPTH) ? sym_strx[i] : 32'h0;
   endfunction

   // binary search for the entry of one stab type covering an address
   function automatic void narrow_range(inout int lo, inout int hi, input logic [7:0] ty,
                                        input logic [31:0] addr);
      int  l, r, mid, m, k;
      bit  matched;
      l = lo;
      r = hi;
      matched = 0;
      while (l <= r) begin
         mid = (l + r) / 2;
         m = mid;
         while (m >= l && type_at(m) != ty) m--;
         if (m < l) begin
            l = mid + 1;
            continue;
         end
         matched = 1;
         if (value_at(m) < addr) begin
            lo = m;
            l = mid + 1;
         end else if (value_at(m) > addr) begin
            hi = m - 1;
            r = m - 1;
         end else begin
            lo = m;
            l = m;
            addr = addr + 32'd1;
         end
      end
      if (!matched) begin
         hi = lo - 1;
      end else begin
         k = hi;
         while (k > lo && type_at(k) != ty) k--;
         lo = k;
      end
   endfunction

   function automatic lookup_type resolve_address(logic [31:0] query);
      lookup_type res;
      logic [31:0] addr;
      int cnt, lfile, rfile, lfun, rfun, lline, rline, k;
      res = '0;
      addr = query;
      res.fn_addr = query;
      cnt = (cfg_count > DEPTH) ? DEPTH : int'(cfg_count);
      if (query < cfg_base || !cfg_str_valid) begin
         res.status = sasl_pkg::STATUS_BAD;
         return res;
      end
      lfile = 0;
      rfile = cnt - 1;
      narrow_range(lfile, rfile, sasl_pkg::TYPE_SO, addr);
      if (lfile == 0) begin
         res.status = sasl_pkg::STATUS_NO_FILE;
         return res;
      end
      lfun = lfile;
      rfun = rfile;
      narrow_range(lfun, rfun, sasl_pkg::TYPE_FUN, addr);
      if (lfun <= rfun) begin
         if (strx_at(lfun) < cfg_str_size) begin
            res.fn_off = strx_at(lfun);
            res.fn_known = 1;
         end
         res.fn_addr = value_at(lfun);
         addr = addr - res.fn_addr;
         lline = lfun;
         rline = rfun;
      end else begin
         lline = lfile;
         rline = rfile;
      end
      narrow_range(lline, rline, sasl_pkg::TYPE_SLINE, addr);
      if (lline > rline) begin
         res.status = sasl_pkg::STATUS_NO_LINE;
         return res;
      end
      res.line = (rline >= 0 && rline < DEPTH) ? sym_desc[rline] : 16'h0;
      while (lline >= lfile && type_at(lline) != sasl_pkg::TYPE_SOL &&
             (type_at(lline) != sasl_pkg::TYPE_SO || value_at(lline) == 0)) lline--;
      if (lline >= lfile && strx_at(lline) < cfg_str_size) begin
         res.file_off = strx_at(lline);
         res.file_known = 1;
      end
      if (lfun < rfun)
         for (k = lfun + 1; k < rfun && type_at(k) == sasl_pkg::TYPE_PSYM; k++)
            if (res.nargs != 12'hFFF) res.nargs++;
      res.status = sasl_pkg::STATUS_FOUND;
      return res;
   endfunction

   // one transaction on the request channel; start stays high until the next call or wait_idle
   task automatic send_item(input logic op, input logic [11:0] idx, input logic [7:0] ty,
                            input logic [31:0] val, input logic [31:0] strx,
                            input logic [15:0] desc, input logic [31:0] query);
      if ($urandom_range(0, 99) < gap_pct) begin
         start <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start <= 1;
      req_opcode <= op;
      req_entry_index <= idx;
      req_entry_type <= ty;
      req_entry_value <= val;
      req_entry_string_offset <= strx;
      req_entry_desc <= desc;
      req_query_address <= query;
      do @(posedge clock); while (busy);
      if (op == sasl_pkg::OP_WRITE) begin
         sym_type[idx] = ty;
         sym_value[idx] = val;
         sym_strx[idx] = strx;
         sym_desc[idx] = desc;
      end else begin
         pending_lookups.push_back(resolve_address(query));
      end
   endtask

   task automatic put_entry(inout int i, input logic [7:0] ty, input logic [31:0] val,
                            input logic [31:0] strx, input logic [15:0] desc);
      send_item(sasl_pkg::OP_WRITE, i[11:0], ty, val, strx, desc, $urandom);
      i++;
   endtask

   task automatic query(input logic [31:0] addr);
      send_item(sasl_pkg::OP_QUERY, 12'($urandom), 8'($urandom), $urandom, $urandom,
                16'($urandom), addr);
   endtask

   // wait for every outstanding result and let the block settle
   task automatic wait_idle();
      start <= 0;
      @(posedge clock);
      while (pending_lookups.size() != 0 || busy) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
      case (idx)
         sasl_pkg::REG_ENTRY_COUNT: cfg_count = val[12:0];
         sasl_pkg::REG_STR_SIZE:    cfg_str_size = val;
         sasl_pkg::REG_STR_VALID:   cfg_str_valid = val[0];
         sasl_pkg::REG_KERNEL_BASE: cfg_base = val;
      endcase
   endtask

   function automatic logic [7:0] pick_type();
      case ($urandom_range(0, 5))
         0: return sasl_pkg::TYPE_FUN;
         1: return sasl_pkg::TYPE_SLINE;
         2: return sasl_pkg::TYPE_SO;
         3: return sasl_pkg::TYPE_SOL;
         4: return sasl_pkg::TYPE_PSYM;
         default: return 8'($urandom);
      endcase
   endfunction

   // well-formed stab layout from slot 0: files, functions, parameters, lines
   task automatic load_session(input bit with_lines, output int n);
      int i, nf, nfn, np, nl;
      logic [31:0] a, rel;
      i = 0;
      put_entry(i, 8'($urandom), $urandom, $urandom, 16'($urandom));
      a = cfg_base + $urandom_range(0, 'h1000);
      sess_lo = a;
      nf = $urandom_range(1, 3);
      for (int f = 0; f < nf; f++) begin
         put_entry(i, sasl_pkg::TYPE_SO, a, $urandom_range(0, 1200), 16'($urandom));
         if ($urandom_range(0, 1))
            put_entry(i, sasl_pkg::TYPE_SOL, a, $urandom_range(0, 1200), 16'd0);
         nfn = $urandom_range(0, 3);
         for (int g = 0; g < nfn; g++) begin
            a = a + $urandom_range(0, 8);
            put_entry(i, sasl_pkg::TYPE_FUN, a, $urandom_range(0, 1200), 16'($urandom));
            np = $urandom_range(0, 3);
            for (int p = 0; p < np; p++)
               put_entry(i, sasl_pkg::TYPE_PSYM, $urandom, $urandom, 16'($urandom));
            rel = 0;
            nl = with_lines ? $urandom_range(1, 5) : 0;
            for (int q = 0; q < nl; q++) begin
               if ($urandom_range(0, 7) == 0)
                  put_entry(i, sasl_pkg::TYPE_SOL, a, $urandom_range(0, 1200), 16'd0);
               put_entry(i, sasl_pkg::TYPE_SLINE, rel, $urandom, 16'($urandom));
               rel = rel + $urandom_range(1, 16);
            end
            if ($urandom_range(0, 5) == 0)
               put_entry(i, pick_type(), $urandom, $urandom, 16'($urandom));
            a = a + rel;
         end
         if ($urandom_range(0, 2) == 0)
            put_entry(i, sasl_pkg::TYPE_SO, 32'd0, $urandom_range(0, 1200), 16'd0);
      end
      sess_hi = a;
      n = i;
   endtask

   task automatic query_session(input int nq);
      for (int q = 0; q < nq; q++)
         case ($urandom_range(0, 7))
            0: query($urandom);
            1: query(sess_lo - $urandom_range(0, 8));
            default: query(sess_lo + $urandom_range(0, sess_hi - sess_lo + 24));
         endcase
   endtask

   task automatic run_session(input bit with_lines, input int nq);
      int n;
      wait_idle();
      load_session(with_lines, n);
      wait_idle();
      write_reg(sasl_pkg::REG_ENTRY_COUNT,
                n + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0));
      query_session(nq);
   endtask

   task automatic test_fill_table();
      for (int i = 0; i < FILL; i++)
         send_item(sasl_pkg::OP_WRITE, i[11:0], pick_type(), $urandom, $urandom,
                   16'($urandom), 32'd0);
   endtask

   task automatic test_register_corners();
      wait_idle();
      query(32'hFFFF_FFFF);
      wait_idle();
      write_reg(sasl_pkg::REG_STR_VALID, 32'd1);
      write_reg(sasl_pkg::REG_STR_SIZE, 32'd1000);
      query(32'hC000_0100);
      query(32'h0000_0000);
      wait_idle();
      write_reg(sasl_pkg::REG_ENTRY_COUNT, FILL);
      query(32'hFFFF_FFFF);
      query($urandom);
      wait_idle();
      write_reg(sasl_pkg::REG_KERNEL_BASE, 32'd0);
      query(32'd0);
      query($urandom);
      wait_idle();
      write_reg(sasl_pkg::REG_ENTRY_COUNT, FILL - 1);
      query($urandom);
      wait_idle();
      write_reg(sasl_pkg::REG_ENTRY_COUNT, 32'd1);
      query($urandom);
      wait_idle();
      write_reg(sasl_pkg::REG_KERNEL_BASE, 32'hFFFF_FFFF);
      query(32'hFFFF_FFFE);
      query(32'hFFFF_FFFF);
   endtask

   task automatic test_directed_layouts();
      wait_idle();
      write_reg(sasl_pkg::REG_KERNEL_BASE, 32'hC000_0000);
      run_session(1, 6);
      run_session(0, 4);
      wait_idle();
      write_reg(sasl_pkg::REG_STR_SIZE, 32'd0);
      query_session(4);
      wait_idle();
      write_reg(sasl_pkg::REG_STR_SIZE, 32'hFFFF_FFFF);
      query_session(4);
   endtask

   task automatic test_random_sessions(input int pct, input int nsess);
      gap_pct = pct;
      for (int s = 0; s < nsess; s++) begin
         wait_idle();
         if ($urandom_range(0, 3) == 0)
            write_reg(sasl_pkg::REG_STR_SIZE, $urandom_range(0, 1300));
         if ($urandom_range(0, 7) == 0) write_reg(sasl_pkg::REG_KERNEL_BASE, $urandom);
         run_session($urandom_range(0, 5) != 0, $urandom_range(8, 20));
      end
   endtask

   always @(posedge clock) begin
      lookup_type want;
      if (rsp_valid) begin
         if (pending_lookups.size() == 0) begin
            $display("%t unexpected result status %0d", $time, rsp_status);
            errors++;
         end else begin
            want = pending_lookups.pop_front();
            if (want.status !== rsp_status) begin
               $display("%t status exp %0d got %0d", $time, want.status, rsp_status);
               errors++;
            end
            if (want.line !== rsp_line_number) begin
               $display("%t line exp %0d got %0d", $time, want.line, rsp_line_number);
               errors++;
            end
            if (want.fn_addr !== rsp_function_address) begin
               $display("%t fn addr exp %h got %h", $time, want.fn_addr, rsp_function_address);
               errors++;
            end
            if (want.fn_off !== rsp_function_name_offset) begin
               $display("%t fn name exp %h got %h", $time, want.fn_off,
                        rsp_function_name_offset);
               errors++;
            end
            if (want.fn_known !== rsp_function_name_known) begin
               $display("%t fn known exp %b got %b", $time, want.fn_known,
                        rsp_function_name_known);
               errors++;
            end
            if (want.file_off !== rsp_file_name_offset) begin
               $display("%t file name exp %h got %h", $time, want.file_off, rsp_file_name_offset);
               errors++;
            end
            if (want.file_known !== rsp_file_name_known) begin
               $display("%t file known exp %b got %b", $time, want.file_known,
                        rsp_file_name_known);
               errors++;
            end
            if (want.nargs !== rsp_argument_count) begin
               $display("%t args exp %0d got %0d", $time, want.nargs, rsp_argument_count);
               errors++;
            end
         end
      end
   end

   // watchdog: cycles with no transaction anywhere
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (psel && penable)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles > STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_fill_table();
      test_register_corners();
      test_directed_layouts();
      test_random_sessions(35, 6);
      test_random_sessions(81, 6);
      test_random_sessions(0, 6);
      wait_idle();
      repeat (40) @(posedge clock);
      if (errors == 0 && pending_lookups.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== stab_address_symbol_lookup.f =====
hdl/sasl_pkg.sv
hdl/sasl_ram.sv
hdl/stab_address_symbol_lookup.sv
hdl/sasl_checker.sv
dv/stab_address_symbol_lookup_tb.sv
